// File: hdl/pps_pkg.sv
// Shared types and constants for the preemptive priority scheduler.
package pps_pkg;

   // One ready-queue slot.
   typedef struct packed {
      logic [7:0]  id;
      logic [7:0]  prio;
      logic [31:0] arrival;
      logic [15:0] burst;
      logic [15:0] remaining;
      logic [31:0] first_start;
      logic        started;
   } entry_type;

   typedef enum logic [2:0] {
      ST_ACCEPTED   = 3'd0,
      ST_FULL       = 3'd1,
      ST_ZERO_BURST = 3'd2,
      ST_IDLE       = 3'd3,
      ST_RAN        = 3'd4,
      ST_FINISHED   = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      ALU_CLK_INC,
      ALU_TURN,
      ALU_WAIT,
      ALU_RESP
   } alu_op_type;

   // Operand sources offered to the shared time subtractor.
   typedef struct packed {
      logic [31:0] clock;
      logic [31:0] arrival;
      logic [15:0] burst;
      logic [31:0] first_start;
      logic [31:0] turn;
   } alu_opnd_type;

   // Increment is done as a subtraction of minus one.
   localparam logic [31:0] TIME_MINUS_ONE = 32'hFFFF_FFFF;

endpackage

// File: hdl/pps_alu.sv
// Shared 32-bit time subtractor with operand selection.
module pps_alu (
   input  pps_pkg::alu_op_type   op,
   input  pps_pkg::alu_opnd_type opnd,
   output logic [31:0]           result
);

   logic [31:0] opa;
   logic [31:0] opb;

   always_comb begin
      case (op)
         pps_pkg::ALU_CLK_INC: begin
            opa = opnd.clock;
            opb = pps_pkg::TIME_MINUS_ONE;
         end
         pps_pkg::ALU_TURN: begin
            opa = opnd.clock;
            opb = opnd.arrival;
         end
         pps_pkg::ALU_WAIT: begin
            opa = opnd.turn;
            opb = {16'd0, opnd.burst};
         end
         pps_pkg::ALU_RESP: begin
            opa = opnd.first_start;
            opb = opnd.arrival;
         end
         default: begin
            opa = opnd.clock;
            opb = pps_pkg::TIME_MINUS_ONE;
         end
      endcase
      result = opa - opb;
   end

endmodule

// File: hdl/pps_queue.sv
// Ready-queue storage: one write port, one registered read port.
module pps_queue #(
   parameter int DEPTH = 16,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  pps_pkg::entry_type  wr_data,
   input  logic [AW-1:0]       rd_addr,
   output pps_pkg::entry_type  rd_data
);

   pps_pkg::entry_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

// File: hdl/preemptive_priority_scheduler_top.sv
// Top level of the preemptive priority scheduler: sequencer, running job and result register.
//
//   channel | direction | handshake         | payload
//   --------+-----------+-------------------+-----------------------------------------------
//   req     | in        | req_valid/stall   | mode, proc_id, priority_req, burst
//   rsp     | out       | rsp_valid/stall   | status, running_id, preempted(_id), clock_now,
//           |           |                   | done_id, turnaround, waiting, response
//
// An arrival walks the queue from the tail to place its entry; a tick runs a head read,
// a pop shift, a reinsert shift, execute and up to three time subtractions, as needed.
// The queue memory has a single read and a single write port, so each shifted entry takes
// a read state and a write state. req_stall is low only in the idle state.
// A finished result waits in the output register, so the next transfer on req is
// taken while rsp is stalled. Reset clears queue count, clock, running job and valid.
module preemptive_priority_scheduler_top #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [7:0]  req_proc_id,
   input  logic [7:0]  req_priority_req,
   input  logic [15:0] req_burst,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_running_id,
   output logic        rsp_preempted,
   output logic [7:0]  rsp_preempted_id,
   output logic [31:0] rsp_clock_now,
   output logic [7:0]  rsp_done_id,
   output logic [31:0] rsp_turnaround,
   output logic [31:0] rsp_waiting,
   output logic [31:0] rsp_response
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_HEAD_RD,
      S_HEAD_CAP,
      S_POP_RD,
      S_POP_WR,
      S_INS_RD,
      S_INS_CMP,
      S_LOAD,
      S_EXEC,
      S_TURN,
      S_WAIT,
      S_RESP,
      S_OUT
   } state_type;

   typedef struct packed {
      pps_pkg::status_type status;
      logic [7:0]          running_id;
      logic                preempted;
      logic [7:0]          preempted_id;
      logic [31:0]         clock_now;
      logic [7:0]          done_id;
      logic [31:0]         turnaround;
      logic [31:0]         waiting;
      logic [31:0]         response;
   } result_type;

   // Control state.
   state_type          state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic               busy_ff, busy_in;
   logic [31:0]        clock_ff, clock_in;
   logic               rsp_valid_ff, rsp_valid_in;
   pps_pkg::entry_type run_ff, run_in;

   // Per-item working registers.
   logic               mode_ff, mode_in;
   logic               preempt_ff, preempt_in;
   logic [CW-1:0]      idx_ff, idx_in;
   pps_pkg::entry_type ins_ff, ins_in;
   pps_pkg::entry_type head_ff, head_in;
   result_type         res_ff, res_in;
   result_type         out_ff, out_in;

   // Queue memory and shared unit hookup.
   logic                  mem_wr_en;
   logic [AW-1:0]         mem_wr_addr;
   pps_pkg::entry_type    mem_wr_data;
   logic [AW-1:0]         mem_rd_addr;
   pps_pkg::entry_type    mem_rd_data;
   pps_pkg::alu_op_type   alu_op;
   pps_pkg::alu_opnd_type alu_opnd;
   logic [31:0]           alu_result;
   logic [CW-1:0]         idx_dec;

   pps_queue #(
      .DEPTH (QUEUE_DEPTH),
      .AW    (AW)
   ) u_queue (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   pps_alu u_alu (
      .op     (alu_op),
      .opnd   (alu_opnd),
      .result (alu_result)
   );

   assign idx_dec = idx_ff - CW'(1);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      busy_in      = busy_ff;
      clock_in     = clock_ff;
      run_in       = run_ff;
      mode_in      = mode_ff;
      preempt_in   = preempt_ff;
      idx_in       = idx_ff;
      ins_in       = ins_ff;
      head_in      = head_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      rsp_valid_in = rsp_valid_ff;

      mem_wr_en   = 1'b0;
      mem_wr_addr = idx_ff[AW-1:0];
      mem_wr_data = ins_ff;
      mem_rd_addr = '0;

      alu_op               = pps_pkg::ALU_CLK_INC;
      alu_opnd.clock       = clock_ff;
      alu_opnd.arrival     = run_ff.arrival;
      alu_opnd.burst       = run_ff.burst;
      alu_opnd.first_start = run_ff.first_start;
      alu_opnd.turn        = res_ff.turnaround;

      // Drop the held result once the consumer takes it.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               res_in        = '0;
               res_in.status = pps_pkg::ST_ACCEPTED;
               mode_in       = req_mode;
               preempt_in    = 1'b0;
               if (!req_mode) begin
                  if (count_ff == CW'(QUEUE_DEPTH)) begin
                     res_in.status = pps_pkg::ST_FULL;
                     state_in      = S_OUT;
                  end else if (req_burst == 16'd0) begin
                     res_in.status = pps_pkg::ST_ZERO_BURST;
                     state_in      = S_OUT;
                  end else begin
                     ins_in.id          = req_proc_id;
                     ins_in.prio        = req_priority_req;
                     ins_in.arrival     = clock_ff;
                     ins_in.burst       = req_burst;
                     ins_in.remaining   = req_burst;
                     ins_in.first_start = '0;
                     ins_in.started     = 1'b0;
                     idx_in             = count_ff;
                     state_in           = S_INS_RD;
                  end
               end else if (count_ff != '0) begin
                  state_in = S_HEAD_RD;
               end else begin
                  state_in = S_EXEC;
               end
            end
         end

         S_HEAD_RD: begin
            mem_rd_addr = '0;
            state_in    = S_HEAD_CAP;
         end

         // Decide between preempt, dispatch and plain run.
         S_HEAD_CAP: begin
            head_in = mem_rd_data;
            if (busy_ff && (mem_rd_data.prio < run_ff.prio)) begin
               preempt_in          = 1'b1;
               res_in.preempted    = 1'b1;
               res_in.preempted_id = run_ff.id;
               idx_in              = CW'(1);
               state_in            = S_POP_RD;
            end else if (!busy_ff) begin
               idx_in   = CW'(1);
               state_in = S_POP_RD;
            end else begin
               state_in = S_EXEC;
            end
         end

         // Shift entries one slot toward the head.
         S_POP_RD: begin
            if (idx_ff >= count_ff) begin
               count_in = count_ff - CW'(1);
               if (preempt_ff) begin
                  ins_in.id          = run_ff.id;
                  ins_in.prio        = run_ff.prio;
                  ins_in.arrival     = run_ff.arrival;
                  ins_in.burst       = run_ff.burst;
                  ins_in.remaining   = run_ff.remaining;
                  ins_in.first_start = run_ff.first_start;
                  ins_in.started     = 1'b1;
                  idx_in             = count_ff - CW'(1);
                  state_in           = S_INS_RD;
               end else begin
                  state_in = S_LOAD;
               end
            end else begin
               mem_rd_addr = idx_ff[AW-1:0];
               state_in    = S_POP_WR;
            end
         end

         S_POP_WR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = idx_dec[AW-1:0];
            mem_wr_data = mem_rd_data;
            idx_in      = idx_ff + CW'(1);
            state_in    = S_POP_RD;
         end

         // Walk from the tail, moving less urgent entries back one slot.
         S_INS_RD: begin
            if (idx_ff == '0) begin
               mem_wr_en = 1'b1;
               count_in  = count_ff + CW'(1);
               state_in  = mode_ff ? S_LOAD : S_OUT;
            end else begin
               mem_rd_addr = idx_dec[AW-1:0];
               state_in    = S_INS_CMP;
            end
         end

         S_INS_CMP: begin
            mem_wr_en = 1'b1;
            if (mem_rd_data.prio > ins_ff.prio) begin
               mem_wr_data = mem_rd_data;
               idx_in      = idx_dec;
               state_in    = S_INS_RD;
            end else begin
               count_in = count_ff + CW'(1);
               state_in = mode_ff ? S_LOAD : S_OUT;
            end
         end

         S_LOAD: begin
            run_in = head_ff;
            if (!head_ff.started) begin
               run_in.first_start = clock_ff;
            end
            busy_in  = 1'b1;
            state_in = S_EXEC;
         end

         // Advance the clock and, if a job is running, run one unit of it.
         S_EXEC: begin
            alu_op   = pps_pkg::ALU_CLK_INC;
            clock_in = alu_result;
            if (busy_ff) begin
               res_in.running_id = run_ff.id;
               run_in.remaining  = run_ff.remaining - 16'd1;
               if (run_ff.remaining == 16'd1) begin
                  state_in = S_TURN;
               end else begin
                  res_in.status = pps_pkg::ST_RAN;
                  state_in      = S_OUT;
               end
            end else begin
               res_in.status = pps_pkg::ST_IDLE;
               state_in      = S_OUT;
            end
         end

         S_TURN: begin
            alu_op            = pps_pkg::ALU_TURN;
            res_in.turnaround = alu_result;
            state_in          = S_WAIT;
         end

         S_WAIT: begin
            alu_op         = pps_pkg::ALU_WAIT;
            res_in.waiting = alu_result;
            state_in       = S_RESP;
         end

         S_RESP: begin
            alu_op          = pps_pkg::ALU_RESP;
            res_in.response = alu_result;
            res_in.status   = pps_pkg::ST_FINISHED;
            res_in.done_id  = run_ff.id;
            busy_in         = 1'b0;
            state_in        = S_OUT;
         end

         // Hold until the output register is free.
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_in           = res_ff;
               out_in.clock_now = clock_ff;
               rsp_valid_in     = 1'b1;
               state_in         = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         busy_ff      <= 1'b0;
         clock_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         run_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         busy_ff      <= busy_in;
         clock_ff     <= clock_in;
         rsp_valid_ff <= rsp_valid_in;
         run_ff       <= run_in;
      end
      mode_ff    <= mode_in;
      preempt_ff <= preempt_in;
      idx_ff     <= idx_in;
      ins_ff     <= ins_in;
      head_ff    <= head_in;
      res_ff     <= res_in;
      out_ff     <= out_in;
   end

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = out_ff.status;
   assign rsp_running_id   = out_ff.running_id;
   assign rsp_preempted    = out_ff.preempted;
   assign rsp_preempted_id = out_ff.preempted_id;
   assign rsp_clock_now    = out_ff.clock_now;
   assign rsp_done_id      = out_ff.done_id;
   assign rsp_turnaround   = out_ff.turnaround;
   assign rsp_waiting      = out_ff.waiting;
   assign rsp_response     = out_ff.response;

   // The queue never holds more entries than it has slots.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   // A result appears only out of the output state.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("result raised outside output state");

   // An accepted transfer always starts work.
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != S_IDLE))
      else $error("accepted transfer did not start work");

   // The running job is released only by completion.
   a_busy_release: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy_ff) && !$past(reset)) |-> $past(state_ff == S_RESP))
      else $error("running job dropped without finishing");

endmodule
